>>> rtl/utf8_stream_decoder_defines.svh
// Assertion macros shared by the decoder RTL.
// Each macro expects signals clk and rst_n in scope.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define U8SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define U8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/u8sd_pkg.sv
`default_nettype none

package u8sd_pkg;

    localparam int unsigned CU_W = 21;

    localparam logic [31:0]     UNI_MAX       = 32'h0010_FFFF;
    localparam logic [31:0]     SURR_LO       = 32'h0000_D800;
    localparam logic [31:0]     SURR_HI       = 32'h0000_DFFF;
    localparam logic [CU_W-1:0] SURR_HI_BASE  = 21'h00D800;
    localparam logic [CU_W-1:0] SURR_LOW_BASE = 21'h00DC00;
    localparam logic [CU_W-1:0] SUPP_BASE     = 21'h010000;
    localparam logic [CU_W-1:0] REPL_CHAR     = 21'h00003F;

    // Input beat: one raw byte of the stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_beat_t;

    // Output beat: one code point or UTF-16 unit
    typedef struct packed {
        logic [CU_W-1:0] code_unit;
        logic            replaced;
        logic            last;
    } out_beat_t;

    // Number of trailing bytes announced by a lead byte
    function automatic logic [2:0] lead_extra(input logic [7:0] b);
        logic [2:0] n;
        begin
            if (b < 8'hC0)
                n = 3'd0;
            else if (b < 8'hE0)
                n = 3'd1;
            else if (b < 8'hF0)
                n = 3'd2;
            else if (b < 8'hF8)
                n = 3'd3;
            else if (b < 8'hFC)
                n = 3'd4;
            else
                n = 3'd5;
            return n;
        end
    endfunction

    // Marker bits accumulated by a sequence of the given length
    function automatic logic [31:0] len_offset(input logic [2:0] extra);
        logic [31:0] off;
        begin
            case (extra)
                3'd1:    off = 32'h0000_3080;
                3'd2:    off = 32'h000E_2080;
                3'd3:    off = 32'h03C8_2080;
                3'd4:    off = 32'hFA08_2080;
                3'd5:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// Channel  | Valid      | Stall      | Payload                  | Direction
// ---------+------------+------------+--------------------------+----------
// input    | in_valid   | in_stall   | in_data  (in_beat_t)     | to block
// output   | out_valid  | out_stall  | out_data (out_beat_t)    | from block
// config   | cfg_wr_en  | -          | cfg_wr_data (utf16 mode) | to block
//
// One byte is taken per cycle while in_stall is low; the sequence accumulator updates
// on the accepting edge. A completed sequence is held in the finishing stage, then in
// the output register that drives out_data. A surrogate pair leaves as two units, high
// first; a sequence behind it waits in the finishing stage while the input stalls.
// in_stall follows out_stall combinationally through the finishing stage.
// Reset clears the open sequence, both stages and the UTF-16 mode bit.
`default_nettype none

`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr_en,
    input  wire logic      cfg_wr_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_beat_t  in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_beat_t      out_data
);

    // Mode and sequence state
    logic        utf16_reg;
    logic [31:0] acc_reg,  acc_next;
    logic [2:0]  rem_reg,  rem_next;
    logic [2:0]  ext_reg,  ext_next;

    // Finishing stage: one completed sequence
    logic        s1_valid_reg, s1_valid_next;
    logic [31:0] s1_acc_reg,   s1_acc_next;
    logic [2:0]  s1_ext_reg,   s1_ext_next;

    // Result register and queued low surrogate
    logic        out_valid_reg,  out_valid_next;
    out_beat_t   out_data_reg,   out_data_next;
    logic        pend_valid_reg, pend_valid_next;
    out_beat_t   pend_data_reg,  pend_data_next;

    // Handshake terms
    logic out_take, out_free, s1_adv, in_acc;

    // Byte step terms
    logic        open_lead;
    logic [2:0]  lead_x;
    logic [31:0] acc_step;
    logic [2:0]  rem_step, ext_step;
    logic        seq_done;

    // Finish terms
    logic [31:0]     ch;
    logic            bad;
    logic [CU_W-1:0] cp;
    logic            pair;
    logic [CU_W-1:0] supp;
    out_beat_t       single_beat, hi_beat, lo_beat;

    // Handshake
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || out_take;
    assign s1_adv    = s1_valid_reg && !pend_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Byte step: lead byte loads, trailing byte shifts in six bits
    always_comb
    begin
        open_lead = (rem_reg == 3'd0);
        lead_x    = lead_extra(in_data.data_byte);
        if (open_lead)
        begin
            acc_step = {24'd0, in_data.data_byte};
            rem_step = lead_x;
            ext_step = lead_x;
        end
        else
        begin
            acc_step = {acc_reg[25:0], 6'd0} + {24'd0, in_data.data_byte};
            rem_step = rem_reg - 3'd1;
            ext_step = ext_reg;
        end
        seq_done = (rem_step == 3'd0);
    end

    // Sequence state and finishing stage update
    always_comb
    begin
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        ext_next      = ext_reg;
        s1_acc_next   = s1_acc_reg;
        s1_ext_next   = s1_ext_reg;
        s1_valid_next = s1_valid_reg && !s1_adv;
        if (in_acc)
        begin
            if (seq_done)
            begin
                s1_valid_next = 1'b1;
                s1_acc_next   = acc_step;
                s1_ext_next   = ext_step;
                acc_next      = 32'd0;
                rem_next      = 3'd0;
                ext_next      = 3'd0;
            end
            else if (in_data.end_of_data)
            begin
                // truncated sequence at end of stream is dropped
                acc_next = 32'd0;
                rem_next = 3'd0;
                ext_next = 3'd0;
            end
            else
            begin
                acc_next = acc_step;
                rem_next = rem_step;
                ext_next = ext_step;
            end
        end
    end

    // Finish: strip marker bits, range check, optional surrogate split
    always_comb
    begin
        ch   = s1_acc_reg - len_offset(s1_ext_reg);
        bad  = (ch > UNI_MAX) || ((ch >= SURR_LO) && (ch <= SURR_HI));
        cp   = bad ? REPL_CHAR : ch[CU_W-1:0];
        pair = utf16_reg && (cp >= SUPP_BASE);
        supp = cp - SUPP_BASE;

        single_beat.code_unit = cp;
        single_beat.replaced  = bad;
        single_beat.last      = 1'b1;

        hi_beat.code_unit = SURR_HI_BASE + {11'd0, supp[19:10]};
        hi_beat.replaced  = 1'b0;
        hi_beat.last      = 1'b0;

        lo_beat.code_unit = SURR_LOW_BASE + {11'd0, supp[9:0]};
        lo_beat.replaced  = 1'b0;
        lo_beat.last      = 1'b1;
    end

    // Output register: queued unit first, then the finishing stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = pend_data_reg;
            pend_valid_next = 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = pair ? hi_beat : single_beat;
            pend_valid_next = pair;
            pend_data_next  = lo_beat;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_reg      <= 1'b0;
            acc_reg        <= 32'd0;
            rem_reg        <= 3'd0;
            ext_reg        <= 3'd0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                utf16_reg <= cfg_wr_data;
            end
            acc_reg        <= acc_next;
            rem_reg        <= rem_next;
            ext_reg        <= ext_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_acc_reg    <= s1_acc_next;
        s1_ext_reg    <= s1_ext_next;
        out_data_reg  <= out_data_next;
        pend_data_reg <= pend_data_next;
    end

    // Checks
    `U8SD_ASSERT_NOW(a_pend_behind_out, pend_valid_reg, out_valid_reg,
        "queued low surrogate without a unit in the output register")
    `U8SD_ASSERT_NOW(a_pend_blocks_s1, pend_valid_reg, !s1_adv,
        "finishing stage advanced over a queued low surrogate")
    `U8SD_ASSERT_NOW(a_high_has_low, out_valid_reg && !out_data_reg.last, pend_valid_reg,
        "high surrogate shown without its low unit queued")
    `U8SD_ASSERT_NOW(a_rem_range, 1'b1, rem_reg < 3'd6,
        "trailing byte count beyond five")
    `U8SD_ASSERT_NEXT(a_done_loads_s1, in_acc && seq_done, s1_valid_reg && (rem_reg == 3'd0),
        "completed sequence not handed to the finishing stage")

endmodule

`default_nettype wire
